FILE: sv/c3w_pkg.sv
// Shared types and constants for the 3x3 window filter.
// Depends on nothing; imported by every module of the filter.
package c3w_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned COEF_W    = 12;
  localparam int unsigned CROW_W    = 3 * COEF_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TAPS      = 9;
  localparam int unsigned DIVISOR   = 9;
  localparam int unsigned PIX_MAX   = 255;
  localparam int unsigned DIM_MIN   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

  localparam logic [DIM_W-1:0]  RST_WIDTH    = 11'd426;
  localparam logic [DIM_W-1:0]  RST_HEIGHT   = 11'd240;
  localparam logic [CROW_W-1:0] RST_COEF_ROW = 36'hF00000100;

  typedef logic [PIX_W-1:0] pix_t;

  // per-stage load strobes from the pipeline control to the datapath
  typedef struct packed {
    logic ld_prod;
    logic ld_row;
    logic ld_sum;
    logic ld_div;
    logic ld_out;
  } c3w_adv_t;

endpackage

FILE: sv/conv3x3_window_filter.sv
// 3x3 convolution window filter: top level with line stores, counters,
// pipeline control and the row of window cells. Uses c3w_pkg, c3w_cell, c3w_reduce.
//
// Pixels arrive in raster order, one request per clock while in_stall is low. Two
// single-port-style line stores (one read and one write per pixel each) supply
// the two lines above, and nine window cells shift one column per pixel. Each
// interior pixel (row and column both at least 2) yields one result through the
// stage 1, window, product, row sum, sum, divide and output stages; border pixels
// yield nothing. The sustained rate is one pixel per clock while out_stall is low,
// set by the one read and one write each line store makes per pixel. Every stage
// has its own valid bit, so bubbles collapse and input keeps flowing into empty
// stages while a finished result waits on out_stall. row_end marks the last result
// of a line and frame_end the last of the frame. Width and height are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT when written; the line stores are never cleared,
// so the first two lines after reset only feed border pixels. Write configuration
// only while the pipeline is empty; cfg_ready is always high.
module conv3x3_window_filter import c3w_pkg::*; #(
  parameter int unsigned MAX_WIDTH      = 1024,
  parameter int unsigned MAX_HEIGHT     = 1024,
  parameter int unsigned COEF_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_filtered,
  output logic                 out_row_end,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CROW_W-1:0]    cfg_data
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W = $clog2(MAX_HEIGHT);
  localparam int unsigned PROD_W = PIX_W + COEF_W + 1 - COEF_FRAC_BITS;

  function automatic int unsigned dim_last(input logic [DIM_W-1:0] v,
                                           input int unsigned hi);
    int unsigned u;
    u = 32'(v);
    if (u < DIM_MIN) begin
      dim_last = DIM_MIN - 1;
    end else if (u > hi) begin
      dim_last = hi - 1;
    end else begin
      dim_last = u - 1;
    end
  endfunction

  localparam logic [COL_W-1:0]  RST_COL_LAST  = COL_W'(dim_last(RST_WIDTH, MAX_WIDTH));
  localparam logic [LINE_W-1:0] RST_LINE_LAST = LINE_W'(dim_last(RST_HEIGHT, MAX_HEIGHT));

  // configuration: geometry held as clamped last positions
  logic [COL_W-1:0]  col_last_r;
  logic [LINE_W-1:0] line_last_r;
  logic [CROW_W-1:0] coef_row_r [3];

  // position of the next pixel
  logic [COL_W-1:0]  col_cnt_r;
  logic [LINE_W-1:0] line_cnt_r;

  // stage 1: pixel plus the two line store reads
  logic              v1_r;
  pix_t              px1_r;
  pix_t              up_rd_r;
  pix_t              mid_rd_r;
  logic [COL_W-1:0]  idx1_r;
  logic              emit1_r;
  logic [1:0]        flg1_r;

  // stages 2..7 (window, products, row sums, sum, divide, output)
  logic       v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic [1:0] flg2_r, flg3_r, flg4_r, flg5_r, flg6_r, flg7_r;
  logic       rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
  logic       accept, mv1;
  logic       at_col_last, at_line_last, emit;
  c3w_adv_t   adv;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  pix_t                     col_in [3];
  pix_t                     win    [TAPS];
  logic signed [PROD_W-1:0] prod   [TAPS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r  <= RST_COL_LAST;
      line_last_r <= RST_LINE_LAST;
      for (int r = 0; r < 3; r++) begin
        coef_row_r[r] <= RST_COEF_ROW;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  col_last_r    <= COL_W'(dim_last(cfg_data[DIM_W-1:0], MAX_WIDTH));
        REG_IMAGE_HEIGHT: line_last_r   <= LINE_W'(dim_last(cfg_data[DIM_W-1:0], MAX_HEIGHT));
        REG_COEF_TOP:     coef_row_r[0] <= cfg_data;
        REG_COEF_MID:     coef_row_r[1] <= cfg_data;
        REG_COEF_BOTTOM:  coef_row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ready chain: a stage takes a request when empty or when it hands on its own
  assign rdy7 = !out_valid_r || !out_stall;
  assign rdy6 = !v6_r || rdy7;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;
  assign mv1      = v1_r && rdy2;

  assign adv.ld_prod = v2_r && rdy3;
  assign adv.ld_row  = v3_r && rdy4;
  assign adv.ld_sum  = v4_r && rdy5;
  assign adv.ld_div  = v5_r && rdy6;
  assign adv.ld_out  = v6_r && rdy7;

  // a column or line at or beyond the last position ends the line or frame
  assign at_col_last  = col_cnt_r >= col_last_r;
  assign at_line_last = line_cnt_r >= line_last_r;
  assign emit         = (col_cnt_r >= COL_W'(2)) && (line_cnt_r >= LINE_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      line_cnt_r <= '0;
    end else if (accept) begin
      if (at_col_last) begin
        col_cnt_r  <= '0;
        line_cnt_r <= at_line_last ? '0 : line_cnt_r + 1'b1;
      end else begin
        col_cnt_r <= col_cnt_r + 1'b1;
      end
    end
  end

  // line stores: read at the request, write back when the window shifts
  always_ff @(posedge clk) begin
    if (mv1) begin
      upper_mem[idx1_r] <= mid_rd_r;
    end
    if (accept) begin
      up_rd_r <= upper_mem[col_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      middle_mem[idx1_r] <= px1_r;
    end
    if (accept) begin
      mid_rd_r <= middle_mem[col_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1_r   <= in_pixel;
      idx1_r  <= col_cnt_r;
      emit1_r <= emit;
      flg1_r  <= {at_col_last && at_line_last, at_col_last};
    end
  end

  // valid bits; border pixels drop out once they have shifted the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept)          v1_r <= 1'b1;
      else if (mv1)        v1_r <= 1'b0;
      if (mv1)             v2_r <= emit1_r;
      else if (adv.ld_prod) v2_r <= 1'b0;
      if (adv.ld_prod)     v3_r <= 1'b1;
      else if (adv.ld_row) v3_r <= 1'b0;
      if (adv.ld_row)      v4_r <= 1'b1;
      else if (adv.ld_sum) v4_r <= 1'b0;
      if (adv.ld_sum)      v5_r <= 1'b1;
      else if (adv.ld_div) v5_r <= 1'b0;
      if (adv.ld_div)      v6_r <= 1'b1;
      else if (adv.ld_out) v6_r <= 1'b0;
      if (adv.ld_out)      out_valid_r <= 1'b1;
      else if (rdy7)       out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1)         flg2_r <= flg1_r;
    if (adv.ld_prod) flg3_r <= flg2_r;
    if (adv.ld_row)  flg4_r <= flg3_r;
    if (adv.ld_sum)  flg5_r <= flg4_r;
    if (adv.ld_div)  flg6_r <= flg5_r;
    if (adv.ld_out)  flg7_r <= flg6_r;
  end

  // window: three rows of three cells, new column enters at the right
  assign col_in[0] = up_rd_r;
  assign col_in[1] = mid_rd_r;
  assign col_in[2] = px1_r;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_cell
      pix_t cell_in;
      if (k == 2) begin : g_edge
        assign cell_in = col_in[r];
      end else begin : g_link
        assign cell_in = win[3*r+k+1];
      end
      c3w_cell #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_i   (mv1),
        .pix_i     (cell_in),
        .coef_i    ($signed(coef_row_r[r][COEF_W*k +: COEF_W])),
        .ld_prod_i (adv.ld_prod),
        .pix_o     (win[3*r+k]),
        .prod_o    (prod[3*r+k])
      );
    end
  end

  c3w_reduce #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_reduce (
    .clk        (clk),
    .adv_i      (adv),
    .prod_i     (prod),
    .filtered_o (out_filtered)
  );

  assign out_valid     = out_valid_r;
  assign out_row_end   = flg7_r[0];
  assign out_frame_end = flg7_r[1];

  // the line store write-back never hits the address read in the same cycle
  a_no_store_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mv1) |-> (idx1_r != col_cnt_r))
    else $error("line store read and write collide");

  // a line end returns the column count to zero
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && at_col_last) |=> (col_cnt_r == '0))
    else $error("column count did not wrap at line end");

  // frame end only ever comes with a line end
  a_frame_has_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  // the product stage never loads while it holds a product that is not moving on
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (adv.ld_prod && v3_r) |-> adv.ld_row)
    else $error("product stage overwritten");

endmodule

FILE: sv/c3w_cell.sv
// One window cell: holds a window pixel, hands it to its left neighbor on
// every shift, and registers its truncated coefficient product. Uses c3w_pkg.
module c3w_cell import c3w_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            shift_i,
  input  pix_t                            pix_i,
  input  logic signed [COEF_W-1:0]        coef_i,
  input  logic                            ld_prod_i,
  output pix_t                            pix_o,
  output logic signed [PIX_W+COEF_W-COEF_FRAC_BITS:0] prod_o
);

  localparam int unsigned RAW_W  = PIX_W + COEF_W + 1;
  localparam int unsigned PROD_W = RAW_W - COEF_FRAC_BITS;

  pix_t                     pix_r;
  logic signed [RAW_W-1:0]  raw;
  logic [RAW_W-1:0]         mag;
  logic [RAW_W-1:0]         mag_sh;
  logic [PROD_W-1:0]        mag_tr;
  logic signed [PROD_W-1:0] trunc_val;
  logic signed [PROD_W-1:0] prod_r;

  assign raw       = $signed({1'b0, pix_r}) * coef_i;
  assign mag       = raw[RAW_W-1] ? (~raw + 1'b1) : raw;
  assign mag_sh    = mag >> COEF_FRAC_BITS;
  assign mag_tr    = mag_sh[PROD_W-1:0];
  // truncate toward zero: shift the magnitude, then restore the sign
  assign trunc_val = raw[RAW_W-1] ? $signed(~mag_tr + 1'b1) : $signed(mag_tr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift_i) begin
      pix_r <= pix_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_prod_i) begin
      prod_r <= trunc_val;
    end
  end

  assign pix_o  = pix_r;
  assign prod_o = prod_r;

endmodule

FILE: sv/c3w_reduce.sv
// Sum of the nine cell products, divide by nine toward zero, clamp to 0..255.
// Four registered stages driven by c3w_adv_t strobes. Uses c3w_pkg.
module c3w_reduce import c3w_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 8
) (
  input  logic                                        clk,
  input  c3w_adv_t                                    adv_i,
  input  logic signed [PIX_W+COEF_W-COEF_FRAC_BITS:0] prod_i [TAPS],
  output pix_t                                        filtered_o
);

  localparam int unsigned PROD_W    = PIX_W + COEF_W + 1 - COEF_FRAC_BITS;
  localparam int unsigned RSUM_W    = PROD_W + 2;
  localparam int unsigned SUM_W     = PROD_W + 4;
  localparam int unsigned MAG_W     = SUM_W - 1;
  localparam int unsigned DIV_SHIFT = MAG_W + 4;
  localparam int unsigned RECIP_W   = DIV_SHIFT - 3;
  localparam longint unsigned RECIP_VAL = (64'd1 << DIV_SHIFT) / DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  logic signed [RSUM_W-1:0]  rsum_r [3];
  logic signed [SUM_W-1:0]   sum_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          mag_r;
  logic [MAG_W-1:0]          quot_r;
  logic [MAG_W+RECIP_W-1:0]  scaled;
  logic [MAG_W:0]            rem;
  logic [MAG_W-1:0]          quot;
  pix_t                      filtered_r;

  always_ff @(posedge clk) begin
    if (adv_i.ld_row) begin
      for (int r = 0; r < 3; r++) begin
        rsum_r[r] <= RSUM_W'(prod_i[3*r]) + RSUM_W'(prod_i[3*r+1])
                   + RSUM_W'(prod_i[3*r+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i.ld_sum) begin
      sum_r <= SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);
    end
  end

  // reciprocal estimate; may come out one short of the true quotient
  assign scaled = (MAG_W+RECIP_W)'(sum_r[MAG_W-1:0]) * (MAG_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (adv_i.ld_div) begin
      neg_r  <= sum_r[SUM_W-1];
      mag_r  <= sum_r[MAG_W-1:0];
      quot_r <= MAG_W'(scaled >> DIV_SHIFT);
    end
  end

  assign rem  = (MAG_W+1)'(mag_r) - ((MAG_W+1)'(quot_r) << 3) - (MAG_W+1)'(quot_r);
  assign quot = (rem >= (MAG_W+1)'(DIVISOR)) ? quot_r + 1'b1 : quot_r;

  // negative sums divide to zero or below and clamp to zero
  always_ff @(posedge clk) begin
    if (adv_i.ld_out) begin
      if (neg_r) begin
        filtered_r <= '0;
      end else if (quot > MAG_W'(PIX_MAX)) begin
        filtered_r <= PIX_W'(PIX_MAX);
      end else begin
        filtered_r <= quot[PIX_W-1:0];
      end
    end
  end

  assign filtered_o = filtered_r;

endmodule
